@@ rtl/brjo_pkg.sv @@
package brjo_pkg;

  localparam int DEPTH_DEFAULT   = 4096;
  localparam int RING_SIZE_RESET = 4096;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 13;
  localparam int OFF_W     = 64;
  localparam int STATUS_W  = 3;
  localparam int RSIZE_W   = 13;
  localparam int IN_USER_W  = 8;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_USER_W = 8;
  localparam int OUT_DATA_W = 216;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_REJECT   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

endpackage

@@ rtl/byte_ring_journal_with_offsets_top.sv @@
// Byte ring with absolute 64-bit produced and consumed stream offsets.
// Input requests arrive on in_tvalid/in_tready; in_tuser carries the command
// (append, consume, read at offset) and the batch start flag, in_tdata the
// byte, batch length, read offset and read limit. Every request gives exactly
// one result on out_tvalid/out_tready: status in out_tuser, and in out_tdata
// the byte, next read offset, more flag, retained count, full flag and both
// stream offsets.
// A request lands in the input register, is executed against the ring state
// and the byte store, and its result is shown from the output register (the
// byte comes from the store's registered read port). Throughput is one
// request per cycle while the receiver takes results, set by the single store
// access each request needs. When the receiver stalls, the output register
// holds its result and the input register takes one more request; then
// in_tready drops until the output is taken. Reset empties the ring, zeroes
// both offsets and sets the ring size to 4096 (limited to DEPTH). A write on
// cfg_we sets the ring size and empties the ring the same way; the user must
// issue it only while no request is in flight, which the block does not
// enforce. The byte store itself needs no clearing pass.
module byte_ring_journal_with_offsets_top #(
  parameter int DEPTH = brjo_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [brjo_pkg::RSIZE_W-1:0]      cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command [1:0], batch_start [2], zero fill [7:3]
  input  logic [brjo_pkg::IN_USER_W-1:0]    in_tuser,
  // data_byte [7:0], batch_length [20:8], read_offset [84:21],
  // read_limit [148:85], zero fill [151:149]
  input  logic [brjo_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status [2:0], zero fill [7:3]
  output logic [brjo_pkg::OUT_USER_W-1:0]   out_tuser,
  // data_out [7:0], next_read_offset [71:8], more_follows [72],
  // retained_count [85:73], full_res [86], produced_total [150:87],
  // consumed_total [214:151], zero fill [215]
  output logic [brjo_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = brjo_pkg::LEN_W;
  localparam int OW = brjo_pkg::OFF_W;
  localparam int CAP_RESET = (brjo_pkg::RING_SIZE_RESET > DEPTH) ? DEPTH
                                                                 : brjo_pkg::RING_SIZE_RESET;

  // Input register.
  logic                             s1_valid_r;
  brjo_pkg::cmd_t                   s1_cmd_r;
  logic [brjo_pkg::BYTE_W-1:0]      s1_byte_r;
  logic                             s1_bstart_r;
  logic [LW-1:0]                    s1_blen_r;
  logic [OW-1:0]                    s1_roff_r;
  logic [OW-1:0]                    s1_rlim_r;

  // Ring state.
  logic [CW-1:0]  cap_r;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  held_r, held_nxt;
  logic [OW-1:0]  prod_r, prod_nxt;
  logic [OW-1:0]  cons_r, cons_nxt;
  logic [LW-1:0]  brem_r, brem_nxt;
  logic           drop_r, drop_nxt;

  // Output register.
  logic                             s2_valid_r;
  brjo_pkg::status_t                s2_status_r, status_nxt;
  logic                             s2_dvalid_r, dvalid_nxt;
  logic [OW-1:0]                    s2_noff_r, noff_nxt;
  logic                             s2_more_r, more_nxt;
  logic [CW-1:0]                    s2_held_r;
  logic                             s2_full_r;
  logic [OW-1:0]                    s2_prod_r;
  logic [OW-1:0]                    s2_cons_r;
  logic [brjo_pkg::BYTE_W-1:0]      rdata_r;

  logic [brjo_pkg::BYTE_W-1:0] mem [DEPTH];

  logic                 adv;
  logic                 step;
  logic                 mem_we;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 judge;
  logic [LW-1:0]        len;
  logic [CW-1:0]        free_cnt;
  logic [OW:0]          prod_sum;
  logic [SW-1:0]        tail_sum;
  logic [SW-1:0]        idx_sum;
  logic [SW-1:0]        head_inc;
  logic [CW-1:0]        skip_lo;
  logic [OW-1:0]        skip;
  logic [OW-1:0]        roff_inc;
  logic                 range_bad;
  logic [CW-1:0]        cfg_cap;
  logic [31:0]          rs_ext;

  assign adv       = !s2_valid_r || out_tready;
  assign step      = adv && s1_valid_r;
  assign in_tready = !s1_valid_r || adv;

  // Ring size as written, limited to 1..DEPTH.
  always_comb begin
    rs_ext = 32'(cfg_wdata);
    if (rs_ext == 32'd0) begin
      cfg_cap = CW'(1);
    end else if (rs_ext > 32'(DEPTH)) begin
      cfg_cap = CW'(DEPTH);
    end else begin
      cfg_cap = CW'(rs_ext);
    end
  end

  always_comb begin
    free_cnt = cap_r - held_r;
    prod_sum = {1'b0, prod_r} + (OW+1)'(len);
    tail_sum = SW'(head_r) + SW'(held_r);
    if (tail_sum >= SW'(cap_r)) begin
      tail_sum = tail_sum - SW'(cap_r);
    end
    head_inc = SW'(head_r) + SW'(1);
    skip     = s1_roff_r - cons_r;
    skip_lo  = CW'(s1_roff_r) - CW'(cons_r);
    idx_sum  = SW'(head_r) + SW'(skip_lo);
    if (idx_sum >= SW'(cap_r)) begin
      idx_sum = idx_sum - SW'(cap_r);
    end
    roff_inc  = s1_roff_r + OW'(1);
    range_bad = (s1_roff_r < cons_r) || (s1_roff_r > prod_r) ||
                (s1_rlim_r < s1_roff_r) || (s1_rlim_r > prod_r);
    wr_addr   = AW'(tail_sum);
  end

  always_comb begin
    head_nxt   = head_r;
    held_nxt   = held_r;
    prod_nxt   = prod_r;
    cons_nxt   = cons_r;
    brem_nxt   = brem_r;
    drop_nxt   = drop_r;
    status_nxt = brjo_pkg::ST_OK;
    dvalid_nxt = 1'b0;
    noff_nxt   = '0;
    more_nxt   = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = head_r;
    judge      = 1'b0;
    len        = '0;
    if (s1_bstart_r) begin
      len   = s1_blen_r;
      judge = 1'b1;
    end else if (brem_r == '0) begin
      len   = LW'(1);
      judge = 1'b1;
    end
    case (s1_cmd_r)
      brjo_pkg::CMD_APPEND: begin
        if (judge) begin
          brem_nxt = '0;
          drop_nxt = 1'b0;
          if (len != '0) begin
            if (32'(len) > 32'(free_cnt)) begin
              status_nxt = brjo_pkg::ST_REJECT;
              drop_nxt   = 1'b1;
            end else if (prod_sum[OW]) begin
              status_nxt = brjo_pkg::ST_OVERFLOW;
              drop_nxt   = 1'b1;
            end else begin
              mem_we = 1'b1;
            end
            brem_nxt = len - LW'(1);
            if (len == LW'(1)) begin
              drop_nxt = 1'b0;
            end
          end
        end else begin
          brem_nxt = brem_r - LW'(1);
          if (drop_r) begin
            status_nxt = brjo_pkg::ST_REJECT;
          end else begin
            mem_we = 1'b1;
          end
          if (brem_r == LW'(1)) begin
            drop_nxt = 1'b0;
          end
        end
        if (mem_we) begin
          held_nxt = held_r + CW'(1);
          prod_nxt = prod_r + OW'(1);
        end
      end
      brjo_pkg::CMD_CONSUME: begin
        if (held_r == '0) begin
          status_nxt = brjo_pkg::ST_EMPTY;
        end else begin
          dvalid_nxt = 1'b1;
          head_nxt   = (head_inc >= SW'(cap_r)) ? '0 : AW'(head_inc);
          held_nxt   = held_r - CW'(1);
          cons_nxt   = cons_r + OW'(1);
        end
      end
      brjo_pkg::CMD_READ: begin
        noff_nxt = s1_roff_r;
        if (range_bad) begin
          status_nxt = brjo_pkg::ST_RANGE;
        end else if (s1_rlim_r != s1_roff_r) begin
          if (skip >= OW'(held_r)) begin
            status_nxt = brjo_pkg::ST_RANGE;
          end else begin
            rd_addr    = AW'(idx_sum);
            dvalid_nxt = 1'b1;
            noff_nxt   = roff_inc;
            more_nxt   = roff_inc < s1_rlim_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Byte store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (step && mem_we) begin
      mem[wr_addr] <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CW'(CAP_RESET);
      head_r <= '0;
      held_r <= '0;
      prod_r <= '0;
      cons_r <= '0;
      brem_r <= '0;
      drop_r <= 1'b0;
    end else if (cfg_we) begin
      cap_r  <= cfg_cap;
      head_r <= '0;
      held_r <= '0;
      prod_r <= '0;
      cons_r <= '0;
      brem_r <= '0;
      drop_r <= 1'b0;
    end else if (step) begin
      head_r <= head_nxt;
      held_r <= held_nxt;
      prod_r <= prod_nxt;
      cons_r <= cons_nxt;
      brem_r <= brem_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= brjo_pkg::cmd_t'(in_tuser[1:0]);
      s1_bstart_r <= in_tuser[2];
      s1_byte_r   <= in_tdata[7:0];
      s1_blen_r   <= in_tdata[20:8];
      s1_roff_r   <= in_tdata[84:21];
      s1_rlim_r   <= in_tdata[148:85];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2_status_r <= status_nxt;
      s2_dvalid_r <= dvalid_nxt;
      s2_noff_r   <= noff_nxt;
      s2_more_r   <= more_nxt;
      s2_held_r   <= held_nxt;
      s2_full_r   <= held_nxt == cap_r;
      s2_prod_r   <= prod_nxt;
      s2_cons_r   <= cons_nxt;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tuser  = {(brjo_pkg::OUT_USER_W - brjo_pkg::STATUS_W)'(0), s2_status_r};
  assign out_tdata  = {1'b0,
                       s2_cons_r,
                       s2_prod_r,
                       s2_full_r,
                       brjo_pkg::LEN_W'(s2_held_r),
                       s2_more_r,
                       s2_noff_r,
                       s2_dvalid_r ? rdata_r : 8'd0};

endmodule

@@ rtl/brjo_checker.sv @@
module brjo_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [brjo_pkg::OUT_USER_W-1:0]   out_tuser,
  input logic [brjo_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing is in flight right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // The input side is open right after reset.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // An empty report comes only from an empty ring and carries no byte.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == brjo_pkg::ST_EMPTY |->
      out_tdata[85:73] == '0 && out_tdata[7:0] == '0 &&
      out_tdata[150:87] == out_tdata[214:151])
    else $error("empty status with bytes held");

  // The consumed offset never passes the produced offset.
  a_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[214:151] <= out_tdata[150:87])
    else $error("consumed offset beyond produced offset");

endmodule

bind byte_ring_journal_with_offsets_top brjo_checker u_brjo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
